/* sv/s5rp_pkg.sv */
// Package for the SOCKS5 request parser: request and result types, phase and code constants.
`default_nettype none
package s5rp_pkg;

  typedef enum logic [3:0] {
    PH_VER  = 4'd0,
    PH_CMD  = 4'd1,
    PH_RSV  = 4'd2,
    PH_ATYP = 4'd3,
    PH_DLEN = 4'd4,
    PH_DOM  = 4'd5,
    PH_IPV4 = 4'd6,
    PH_IPV6 = 4'd7,
    PH_PHI  = 4'd8,
    PH_PLO  = 4'd9,
    PH_DONE = 4'd10,
    PH_ERR  = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSING = 2'd0,
    ST_DONE    = 2'd1,
    ST_BAD_ATYP = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ROLE_VER     = 4'd0,
    ROLE_CMD     = 4'd1,
    ROLE_RSV     = 4'd2,
    ROLE_ATYP    = 4'd3,
    ROLE_DLEN    = 4'd4,
    ROLE_ADDR    = 4'd5,
    ROLE_PORT_HI = 4'd6,
    ROLE_PORT_LO = 4'd7,
    ROLE_IGNORED = 4'd8
  } role_t;

  localparam logic [7:0] ATYP_IPV4 = 8'd1;
  localparam logic [7:0] ATYP_DOM  = 8'd3;
  localparam logic [7:0] ATYP_IPV6 = 8'd4;

  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  byte_role;
    logic [7:0]  address_index;
    logic [7:0]  address_byte;
    logic [7:0]  version_seen;
    logic [7:0]  command_seen;
    logic [7:0]  address_kind;
    logic [7:0]  address_length;
    logic [31:0] ipv4_address;
    logic [15:0] port_number;
  } result_t;

endpackage
`default_nettype wire

/* sv/socks5_request_parser_top.sv */
// SOCKS5 connect-request parser top level: per-byte phase update and registered result.
//
// Takes one request byte per cycle and returns one result for each byte, in the cycle after it
// is accepted. The per-byte phase and field update is a single step of combinational logic
// feeding the state and result registers, so a new byte is taken every cycle while the result
// register is empty or being drained; a held result stalls the input only for as long as it
// is not taken. Setting restart on a byte returns the parser to the version phase with all
// captured fields cleared before that byte is parsed.
`default_nettype none
module socks5_request_parser_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire s5rp_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output s5rp_pkg::result_t      result
);

  s5rp_pkg::phase_t phase, phase_next, phase_cur;
  logic [7:0]  version_reg, version_reg_next, version_cur;
  logic [7:0]  command_reg, command_reg_next, command_cur;
  logic [7:0]  kind_reg, kind_reg_next, kind_cur;
  logic [7:0]  length_reg, length_reg_next, length_cur;
  logic [7:0]  remaining, remaining_next, remaining_cur;
  logic [31:0] ipv4_acc, ipv4_acc_next, ipv4_cur;
  logic [15:0] port_reg, port_reg_next, port_cur;
  logic [7:0]  addr_total;
  s5rp_pkg::role_t   role;
  s5rp_pkg::status_t status;
  logic [7:0]  aidx;
  logic [7:0]  abyte;
  logic [7:0]  b;
  logic        accept;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign b          = item.data_byte;

  always_comb begin
    if (item.restart) begin
      phase_cur     = s5rp_pkg::PH_VER;
      version_cur   = '0;
      command_cur   = '0;
      kind_cur      = '0;
      length_cur    = '0;
      remaining_cur = '0;
      ipv4_cur      = '0;
      port_cur      = '0;
    end else begin
      phase_cur     = phase;
      version_cur   = version_reg;
      command_cur   = command_reg;
      kind_cur      = kind_reg;
      length_cur    = length_reg;
      remaining_cur = remaining;
      ipv4_cur      = ipv4_acc;
      port_cur      = port_reg;
    end
  end

  always_comb begin
    phase_next       = phase_cur;
    version_reg_next = version_cur;
    command_reg_next = command_cur;
    kind_reg_next    = kind_cur;
    length_reg_next  = length_cur;
    remaining_next   = remaining_cur;
    ipv4_acc_next    = ipv4_cur;
    port_reg_next    = port_cur;
    role             = s5rp_pkg::ROLE_IGNORED;
    aidx             = '0;
    abyte            = '0;
    addr_total       = length_cur;
    case (phase_cur)
      s5rp_pkg::PH_VER: begin
        version_reg_next = b;
        phase_next       = s5rp_pkg::PH_CMD;
        role             = s5rp_pkg::ROLE_VER;
      end
      s5rp_pkg::PH_CMD: begin
        command_reg_next = b;
        phase_next       = s5rp_pkg::PH_RSV;
        role             = s5rp_pkg::ROLE_CMD;
      end
      s5rp_pkg::PH_RSV: begin
        phase_next = s5rp_pkg::PH_ATYP;
        role       = s5rp_pkg::ROLE_RSV;
      end
      s5rp_pkg::PH_ATYP: begin
        kind_reg_next = b;
        role          = s5rp_pkg::ROLE_ATYP;
        if (b == s5rp_pkg::ATYP_DOM) begin
          phase_next = s5rp_pkg::PH_DLEN;
        end else if (b == s5rp_pkg::ATYP_IPV4) begin
          remaining_next = s5rp_pkg::IPV4_LEN;
          phase_next     = s5rp_pkg::PH_IPV4;
        end else if (b == s5rp_pkg::ATYP_IPV6) begin
          remaining_next  = s5rp_pkg::IPV6_LEN;
          length_reg_next = s5rp_pkg::IPV6_LEN;
          phase_next      = s5rp_pkg::PH_IPV6;
        end else begin
          phase_next = s5rp_pkg::PH_ERR;
        end
      end
      s5rp_pkg::PH_DLEN: begin
        remaining_next  = b;
        length_reg_next = b;
        role            = s5rp_pkg::ROLE_DLEN;
        phase_next      = (b != 8'd0) ? s5rp_pkg::PH_DOM : s5rp_pkg::PH_PHI;
      end
      s5rp_pkg::PH_DOM, s5rp_pkg::PH_IPV4, s5rp_pkg::PH_IPV6: begin
        if (phase_cur == s5rp_pkg::PH_IPV4) begin
          addr_total    = s5rp_pkg::IPV4_LEN;
          ipv4_acc_next = {ipv4_cur[23:0], b};
        end else if (phase_cur == s5rp_pkg::PH_IPV6) begin
          addr_total = s5rp_pkg::IPV6_LEN;
        end
        role           = s5rp_pkg::ROLE_ADDR;
        abyte          = b;
        aidx           = addr_total - remaining_cur;
        remaining_next = remaining_cur - 8'd1;
        if (remaining_next == 8'd0) begin
          phase_next = s5rp_pkg::PH_PHI;
        end
      end
      s5rp_pkg::PH_PHI: begin
        port_reg_next = {b, 8'd0};
        phase_next    = s5rp_pkg::PH_PLO;
        role          = s5rp_pkg::ROLE_PORT_HI;
      end
      s5rp_pkg::PH_PLO: begin
        port_reg_next = {port_cur[15:8], port_cur[7:0] | b};
        phase_next    = s5rp_pkg::PH_DONE;
        role          = s5rp_pkg::ROLE_PORT_LO;
      end
      default: begin
      end
    endcase

    if (phase_next == s5rp_pkg::PH_DONE) begin
      status = s5rp_pkg::ST_DONE;
    end else if (phase_next > s5rp_pkg::PH_DONE) begin
      status = s5rp_pkg::ST_BAD_ATYP;
    end else begin
      status = s5rp_pkg::ST_PARSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= s5rp_pkg::PH_VER;
      version_reg  <= '0;
      command_reg  <= '0;
      kind_reg     <= '0;
      length_reg   <= '0;
      remaining    <= '0;
      ipv4_acc     <= '0;
      port_reg     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        version_reg  <= version_reg_next;
        command_reg  <= command_reg_next;
        kind_reg     <= kind_reg_next;
        length_reg   <= length_reg_next;
        remaining    <= remaining_next;
        ipv4_acc     <= ipv4_acc_next;
        port_reg     <= port_reg_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status         <= status;
      result.byte_role      <= role;
      result.address_index  <= aidx;
      result.address_byte   <= abyte;
      result.version_seen   <= version_reg_next;
      result.command_seen   <= command_reg_next;
      result.address_kind   <= kind_reg_next;
      result.address_length <= length_reg_next;
      result.ipv4_address   <= ipv4_acc_next;
      result.port_number    <= port_reg_next;
    end
  end

endmodule
`default_nettype wire

/* sv/s5rp_checker.sv */
// Port-level checks for the SOCKS5 request parser, bound to the top level.
`default_nettype none
module s5rp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire s5rp_pkg::result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result dropped or changed");

  a_one_per_request: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted request gave no result");

  a_addr_parsing: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_role == s5rp_pkg::ROLE_ADDR
      |-> result.status == s5rp_pkg::ST_PARSING)
    else $error("address byte with final status");

  a_ignored_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.byte_role == s5rp_pkg::ROLE_IGNORED
      |-> result.status != s5rp_pkg::ST_PARSING)
    else $error("ignored byte while still parsing");

endmodule

bind socks5_request_parser_top s5rp_checker u_s5rp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire

/* verif/socks5_request_parser_top_tb.sv */
// Testbench for the SOCKS5 request parser: directed and random byte streams checked per result.
module socks5_request_parser_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BYTES = 1500;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  s5rp_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  s5rp_pkg::result_t result;

  // parser state as the testbench sees it
  s5rp_pkg::phase_t ph;
  logic [7:0]  ver_q, cmd_q, kind_q, len_q, remain_q;
  logic [31:0] ipv4_q;
  logic [15:0] port_q;

  s5rp_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      parsed_bytes = 0;
  int      cycles = 0;
  int      burst_left = 0;
  bit      steady = 1'b0;

  socks5_request_parser_top uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("socks5_request_parser_top test failed");
      $finish;
    end
  end

  function automatic void clear_parser();
    ph = s5rp_pkg::PH_VER;
    ver_q = '0;
    cmd_q = '0;
    kind_q = '0;
    len_q = '0;
    remain_q = '0;
    ipv4_q = '0;
    port_q = '0;
  endfunction

  function automatic s5rp_pkg::result_t parse_byte(logic [7:0] b, logic rs);
    s5rp_pkg::result_t r;
    logic [7:0]        total;
    r = '0;
    r.byte_role = s5rp_pkg::ROLE_IGNORED;
    if (rs) clear_parser();
    case (ph)
      s5rp_pkg::PH_VER: begin
        ver_q = b;
        ph = s5rp_pkg::PH_CMD;
        r.byte_role = s5rp_pkg::ROLE_VER;
      end
      s5rp_pkg::PH_CMD: begin
        cmd_q = b;
        ph = s5rp_pkg::PH_RSV;
        r.byte_role = s5rp_pkg::ROLE_CMD;
      end
      s5rp_pkg::PH_RSV: begin
        ph = s5rp_pkg::PH_ATYP;
        r.byte_role = s5rp_pkg::ROLE_RSV;
      end
      s5rp_pkg::PH_ATYP: begin
        kind_q = b;
        r.byte_role = s5rp_pkg::ROLE_ATYP;
        if (b == s5rp_pkg::ATYP_DOM) begin
          ph = s5rp_pkg::PH_DLEN;
        end else if (b == s5rp_pkg::ATYP_IPV4) begin
          remain_q = s5rp_pkg::IPV4_LEN;
          ph = s5rp_pkg::PH_IPV4;
        end else if (b == s5rp_pkg::ATYP_IPV6) begin
          remain_q = s5rp_pkg::IPV6_LEN;
          len_q = s5rp_pkg::IPV6_LEN;
          ph = s5rp_pkg::PH_IPV6;
        end else begin
          ph = s5rp_pkg::PH_ERR;
        end
      end
      s5rp_pkg::PH_DLEN: begin
        remain_q = b;
        len_q = b;
        r.byte_role = s5rp_pkg::ROLE_DLEN;
        ph = (b != 8'd0) ? s5rp_pkg::PH_DOM : s5rp_pkg::PH_PHI;
      end
      s5rp_pkg::PH_DOM, s5rp_pkg::PH_IPV4, s5rp_pkg::PH_IPV6: begin
        r.byte_role = s5rp_pkg::ROLE_ADDR;
        r.address_byte = b;
        if (ph == s5rp_pkg::PH_IPV4) ipv4_q = {ipv4_q[23:0], b};
        total = (ph == s5rp_pkg::PH_DOM) ? len_q :
                (ph == s5rp_pkg::PH_IPV4) ? s5rp_pkg::IPV4_LEN : s5rp_pkg::IPV6_LEN;
        r.address_index = total - remain_q;
        remain_q = remain_q - 8'd1;
        if (remain_q == 8'd0) ph = s5rp_pkg::PH_PHI;
      end
      s5rp_pkg::PH_PHI: begin
        port_q = {b, 8'd0};
        ph = s5rp_pkg::PH_PLO;
        r.byte_role = s5rp_pkg::ROLE_PORT_HI;
      end
      s5rp_pkg::PH_PLO: begin
        port_q = port_q | {8'd0, b};
        ph = s5rp_pkg::PH_DONE;
        r.byte_role = s5rp_pkg::ROLE_PORT_LO;
      end
      default: ;
    endcase
    if (ph == s5rp_pkg::PH_DONE) r.status = s5rp_pkg::ST_DONE;
    else if (ph > s5rp_pkg::PH_DONE) r.status = s5rp_pkg::ST_BAD_ATYP;
    else r.status = s5rp_pkg::ST_PARSING;
    r.version_seen = ver_q;
    r.command_seen = cmd_q;
    r.address_kind = kind_q;
    r.address_length = len_q;
    r.ipv4_address = ipv4_q;
    r.port_number = port_q;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [7:0] b, input logic rs);
    s5rp_pkg::result_t r;
    if (burst_left == 0) begin
      steady = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 40);
      if (!steady && $urandom_range(0, 1)) begin
        item_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    item.data_byte = b;
    item.restart = rs;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    r = parse_byte(b, rs);
    if (r.byte_role != s5rp_pkg::ROLE_IGNORED) parsed_bytes++;
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  // receiver stalls on modes of its own
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: result_ready = 1'b1;
          1: result_ready = 1'($urandom_range(0, 1));
          2: result_ready = ($urandom_range(0, 3) == 0);
          default: result_ready = ((i % 8) < 5);
        endcase
      end
    end
  end

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    s5rp_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %h", result);
      end else begin
        want = pending_results.pop_front();
        report_field("status", 32'(want.status), 32'(result.status));
        report_field("byte_role", 32'(want.byte_role), 32'(result.byte_role));
        report_field("address_index", 32'(want.address_index),
                     32'(result.address_index));
        report_field("address_byte", 32'(want.address_byte), 32'(result.address_byte));
        report_field("version_seen", 32'(want.version_seen), 32'(result.version_seen));
        report_field("command_seen", 32'(want.command_seen), 32'(result.command_seen));
        report_field("address_kind", 32'(want.address_kind), 32'(result.address_kind));
        report_field("address_length", 32'(want.address_length),
                     32'(result.address_length));
        report_field("ipv4_address", want.ipv4_address, result.ipv4_address);
        report_field("port_number", 32'(want.port_number), 32'(result.port_number));
      end
    end
  end

  task automatic test_ipv4_extremes();
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(s5rp_pkg::ATYP_IPV4, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
  endtask

  task automatic test_ignored_after_done();
    send_request(8'hA5, 1'b0);
    send_request(8'h5A, 1'b0);
  endtask

  task automatic test_empty_domain();
    send_request(8'h00, 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(s5rp_pkg::ATYP_DOM, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
  endtask

  task automatic test_bad_address_type();
    send_request(8'h05, 1'b1);
    send_request(8'h01, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
  endtask

  task automatic random_connect();
    logic [7:0] bytes[$];
    logic [7:0] atyp;
    int         pick;
    int         alen;
    int         abort_at;
    bit         first_restart;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      atyp = s5rp_pkg::ATYP_IPV4;
      alen = 4;
    end else if (pick < 65) begin
      atyp = s5rp_pkg::ATYP_DOM;
      pick = $urandom_range(0, 99);
      if (pick < 2) alen = ($urandom_range(0, 1)) ? 255 : $urandom_range(65, 255);
      else if (pick < 27) alen = $urandom_range(13, 64);
      else alen = $urandom_range(0, 12);
    end else if (pick < 85) begin
      atyp = s5rp_pkg::ATYP_IPV6;
      alen = 16;
    end else begin
      do atyp = 8'($urandom());
      while (atyp == s5rp_pkg::ATYP_IPV4 || atyp == s5rp_pkg::ATYP_DOM ||
             atyp == s5rp_pkg::ATYP_IPV6);
      alen = 0;
    end
    bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'h05);
    bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 3)));
    bytes.push_back(8'($urandom()));
    bytes.push_back(atyp);
    if (atyp == s5rp_pkg::ATYP_DOM) bytes.push_back(8'(alen));
    if (atyp == s5rp_pkg::ATYP_IPV4 || atyp == s5rp_pkg::ATYP_DOM ||
        atyp == s5rp_pkg::ATYP_IPV6) begin
      repeat (alen) bytes.push_back(8'($urandom()));
      bytes.push_back(8'($urandom()));
      bytes.push_back(8'($urandom()));
    end
    repeat (($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0)
      bytes.push_back(8'($urandom()));
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, bytes.size() - 1) : -1;
    first_restart = (ph != s5rp_pkg::PH_VER) || ($urandom_range(0, 2) == 0);
    foreach (bytes[i])
      send_request(bytes[i], (i == 0) ? first_restart : (i == abort_at));
  endtask

  task automatic test_random_requests();
    int start;
    start = parsed_bytes;
    while (parsed_bytes - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_request(8'($urandom()), $urandom_range(0, 3) == 0);
      else
        random_connect();
    end
  endtask

  initial begin
    clear_parser();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_ipv4_extremes();
    test_ignored_after_done();
    test_empty_domain();
    test_bad_address_type();
    test_random_requests();
    item_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("socks5_request_parser_top test passed");
    else
      $display("socks5_request_parser_top test failed");
    $finish;
  end

endmodule

/* sim.f */
sv/s5rp_pkg.sv
sv/socks5_request_parser_top.sv
sv/s5rp_checker.sv
verif/socks5_request_parser_top_tb.sv
